// ===== hdl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: widths, header layout, codes and states.
// Used by the allocator top level and its testbench; depends on nothing.
package ffha_pkg;

   localparam int MAX_GRANULES  = 4096;
   localparam int GRANULE_BYTES = 32;
   localparam int GW            = $clog2(MAX_GRANULES);  // granule index width
   localparam int GCW           = GW + 1;                 // can hold MAX_GRANULES
   localparam int GSH           = $clog2(GRANULE_BYTES);
   localparam int HW            = 1 + 2 * GW;             // header word width

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;

   // Header word: free flag, payload size in granules, previous block.
   typedef struct packed {
      logic          is_free;
      logic [GW-1:0] size;
      logic [GW-1:0] prev;
   } header_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_AREAD,
      ST_ACHECK,
      ST_ASPLIT,
      ST_FREAD,
      ST_FCHECK,
      ST_MREAD,
      ST_MCHECK,
      ST_PREAD,
      ST_PCHECK,
      ST_FWRITE,
      ST_LREAD,
      ST_LWRITE,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic single-port RAM with a registered read port.
// Stand-alone; no package dependencies.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One access a cycle: a write, if enabled, and a registered read of the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: sequencer, header RAM and statistics.
// Depends on ffha_pkg and ffha_ram.
//
// A transaction is taken when start is high and busy is low; busy then stays high
// up to and including the one cycle in which done is high and the result sits on
// the rsp_ ports, which the receiver must take then, as it cannot stall. All header
// accesses share the single header RAM port, so a chain walk reads, then checks,
// each block visited. An allocate walks the chain and, on a split, writes the
// remainder and relinks the block after it, if any; a free walks up to its target,
// merges following free blocks, checks the previous block, writes its header unless
// it merges backwards, relinks the next block, if any, and gives the result.
// Statistics, a zero request and a free with an invalid address go straight to the
// result. busy then goes low, in IDLE, before the next transaction is taken.
// A write to the heap size register restarts the heap (only the first header is
// written; the chain never reaches stale entries).
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [17:0] req_request_bytes,
   input  logic [16:0] req_free_address,
   output logic        done,
   output logic [16:0] rsp_address,
   output logic [16:0] rsp_used_bytes,
   output logic [17:0] rsp_free_bytes,
   output logic [11:0] rsp_used_block_count,
   output logic [11:0] rsp_free_block_count,
   output logic [11:0] rsp_total_block_count,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   localparam int GW  = ffha_pkg::GW;
   localparam int GCW = ffha_pkg::GCW;

   ffha_pkg::state_type  state_ff, state_in;
   logic [GCW-1:0]       heap_ff, heap_in;
   logic [GCW-1:0]       cur_ff, cur_in;      // block being visited
   logic [13:0]          need_ff, need_in;    // granules asked for by an allocate
   logic [GCW-1:0]       tgt_ff, tgt_in;      // free target, then block to relink
   logic [GW-1:0]        aux_ff, aux_in;      // back link for the block to relink
   ffha_pkg::header_type hdr_ff, hdr_in;      // header of the block at cur
   logic [16:0]          used_ff, used_in;
   logic [11:0]          ucnt_ff, ucnt_in;
   logic [11:0]          fcnt_ff, fcnt_in;
   logic [16:0]          addr_ff, addr_in;

   logic                 ram_we;
   logic [GW-1:0]        ram_addr;
   ffha_pkg::header_type ram_wd, ram_rd;
   logic [GCW+1:0]       nxt;                 // next block from read header
   logic [GCW+1:0]       nxt_cur;             // next block from held header
   logic [GCW-1:0]       nb;                  // remainder block after a split
   logic [12:0]          csr_clamped;

   ffha_ram #(.WIDTH(ffha_pkg::HW), .DEPTH(ffha_pkg::MAX_GRANULES)) u_hdr_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // Shared next-block adders.
   assign nxt     = {2'b00, cur_ff} + (GCW+2)'(1) + {{(GCW-GW+2){1'b0}}, ram_rd.size};
   assign nxt_cur = {2'b00, cur_ff} + (GCW+2)'(1) + {{(GCW-GW+2){1'b0}}, hdr_ff.size};
   assign nb      = cur_ff + GCW'(1) + need_ff[GCW-1:0];

   always_comb begin
      if (csr_wr_data < 13'd2)
         csr_clamped = 13'd2;
      else if (csr_wr_data > 13'(ffha_pkg::MAX_GRANULES))
         csr_clamped = 13'(ffha_pkg::MAX_GRANULES);
      else
         csr_clamped = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_INIT;
         heap_ff  <= GCW'(ffha_pkg::MAX_GRANULES);
         used_ff  <= '0;
         ucnt_ff  <= '0;
         fcnt_ff  <= 12'd1;
      end else begin
         state_ff <= state_in;
         heap_ff  <= heap_in;
         used_ff  <= used_in;
         ucnt_ff  <= ucnt_in;
         fcnt_ff  <= fcnt_in;
      end
      cur_ff  <= cur_in;
      need_ff <= need_in;
      tgt_ff  <= tgt_in;
      aux_ff  <= aux_in;
      hdr_ff  <= hdr_in;
      addr_ff <= addr_in;
   end

   // Sequencer: next state, RAM access and statistics updates.
   always_comb begin
      logic [18:0] gr;
      state_in = state_ff;
      heap_in  = heap_ff;
      cur_in   = cur_ff;
      need_in  = need_ff;
      tgt_in   = tgt_ff;
      aux_in   = aux_ff;
      hdr_in   = hdr_ff;
      used_in  = used_ff;
      ucnt_in  = ucnt_ff;
      fcnt_in  = fcnt_ff;
      addr_in  = addr_ff;
      ram_we   = 1'b0;
      ram_addr = cur_ff[GW-1:0];
      ram_wd   = hdr_ff;
      busy     = (state_ff != ffha_pkg::ST_IDLE);
      done     = 1'b0;
      gr       = {1'b0, req_request_bytes} + 19'(ffha_pkg::GRANULE_BYTES - 1);

      case (state_ff)
         ffha_pkg::ST_INIT: begin
            // Restart the heap: one free block at granule 0.
            ram_we   = 1'b1;
            ram_addr = '0;
            ram_wd   = '{is_free: 1'b1, size: GW'(heap_ff - GCW'(1)), prev: '0};
            used_in  = '0;
            ucnt_in  = '0;
            fcnt_in  = 12'd1;
            state_in = ffha_pkg::ST_IDLE;
         end
         ffha_pkg::ST_IDLE: begin
            if (start) begin
               addr_in  = '0;
               cur_in   = '0;
               need_in  = 14'(gr >> ffha_pkg::GSH);
               state_in = ffha_pkg::ST_RESP;
               if (req_op == ffha_pkg::OP_ALLOC) begin
                  if (req_request_bytes != '0)
                     state_in = ffha_pkg::ST_AREAD;
               end else if (req_op == ffha_pkg::OP_FREE) begin
                  tgt_in = GCW'(req_free_address >> ffha_pkg::GSH) - GCW'(1);
                  if (req_free_address != '0 &&
                      req_free_address[ffha_pkg::GSH-1:0] == '0 &&
                      GCW'(req_free_address >> ffha_pkg::GSH) <= heap_ff)
                     state_in = ffha_pkg::ST_FREAD;
               end
            end
         end
         ffha_pkg::ST_AREAD: begin
            state_in = ffha_pkg::ST_ACHECK;
         end
         ffha_pkg::ST_ACHECK: begin
            hdr_in = ram_rd;
            if (ram_rd.is_free && {2'b00, ram_rd.size} >= need_ff) begin
               addr_in = {cur_ff[GW-1:0] + GW'(1), {ffha_pkg::GSH{1'b0}}};
               ucnt_in = ucnt_ff + 12'd1;
               ram_we  = 1'b1;
               if ({2'b00, ram_rd.size} > need_ff + 14'd2) begin
                  // Shrink this block; the remainder is written next.
                  ram_wd   = '{is_free: 1'b0, size: need_ff[GW-1:0], prev: ram_rd.prev};
                  used_in  = used_ff + {need_ff[GW-1:0], {ffha_pkg::GSH{1'b0}}};
                  tgt_in   = nxt[GCW-1:0];
                  state_in = ffha_pkg::ST_ASPLIT;
               end else begin
                  ram_wd   = '{is_free: 1'b0, size: ram_rd.size, prev: ram_rd.prev};
                  used_in  = used_ff + {ram_rd.size, {ffha_pkg::GSH{1'b0}}};
                  fcnt_in  = fcnt_ff - 12'd1;
                  state_in = ffha_pkg::ST_RESP;
               end
            end else begin
               cur_in   = nxt[GCW-1:0];
               state_in = ffha_pkg::ST_AREAD;
               if (nxt >= {2'b00, heap_ff}) state_in = ffha_pkg::ST_RESP;
            end
         end
         ffha_pkg::ST_ASPLIT: begin
            // Write the remainder block; then fix the successor's back link, if any.
            ram_we   = 1'b1;
            ram_addr = nb[GW-1:0];
            ram_wd   = '{is_free: 1'b1,
                         size: hdr_ff.size - need_ff[GW-1:0] - GW'(1),
                         prev: cur_ff[GW-1:0]};
            aux_in   = nb[GW-1:0];
            state_in = (tgt_ff < heap_ff) ? ffha_pkg::ST_LREAD : ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_FREAD: begin
            state_in = ffha_pkg::ST_FCHECK;
         end
         ffha_pkg::ST_FCHECK: begin
            hdr_in = ram_rd;
            if (cur_ff < tgt_ff) begin
               cur_in   = nxt[GCW-1:0];
               state_in = (nxt > {2'b00, tgt_ff}) ? ffha_pkg::ST_RESP : ffha_pkg::ST_FREAD;
            end else if (ram_rd.is_free)
               state_in = ffha_pkg::ST_RESP;
            else begin
               hdr_in.is_free = 1'b1;
               ucnt_in  = ucnt_ff - 12'd1;
               fcnt_in  = fcnt_ff + 12'd1;
               used_in  = used_ff - {ram_rd.size, {ffha_pkg::GSH{1'b0}}};
               state_in = ffha_pkg::ST_MREAD;
            end
         end
         ffha_pkg::ST_MREAD: begin
            // Read the following block, or move on to the previous one.
            if (nxt_cur < {2'b00, heap_ff}) begin
               ram_addr = nxt_cur[GW-1:0];
               state_in = ffha_pkg::ST_MCHECK;
            end else begin
               tgt_in   = heap_ff;
               state_in = ffha_pkg::ST_PREAD;
            end
         end
         ffha_pkg::ST_MCHECK: begin
            if (ram_rd.is_free) begin
               hdr_in.size = hdr_ff.size + ram_rd.size + GW'(1);
               fcnt_in     = fcnt_ff - 12'd1;
               state_in    = ffha_pkg::ST_MREAD;
            end else begin
               // Successor is in use: its back link is fixed at the end.
               tgt_in   = nxt_cur[GCW-1:0];
               state_in = ffha_pkg::ST_PREAD;
            end
         end
         ffha_pkg::ST_PREAD: begin
            if (cur_ff == '0)
               state_in = ffha_pkg::ST_FWRITE;
            else begin
               ram_addr = hdr_ff.prev;
               state_in = ffha_pkg::ST_PCHECK;
            end
         end
         ffha_pkg::ST_PCHECK: begin
            if (ram_rd.is_free) begin
               // Merge into the previous block; this header becomes interior.
               ram_we   = 1'b1;
               ram_addr = hdr_ff.prev;
               ram_wd   = '{is_free: 1'b1, size: ram_rd.size + hdr_ff.size + GW'(1),
                            prev: ram_rd.prev};
               fcnt_in  = fcnt_ff - 12'd1;
               aux_in   = hdr_ff.prev;
               state_in = (tgt_ff < heap_ff) ? ffha_pkg::ST_LREAD : ffha_pkg::ST_RESP;
            end else
               state_in = ffha_pkg::ST_FWRITE;
         end
         ffha_pkg::ST_FWRITE: begin
            // Store the freed, possibly grown, header.
            ram_we   = 1'b1;
            ram_wd   = hdr_ff;
            aux_in   = cur_ff[GW-1:0];
            state_in = (tgt_ff < heap_ff) ? ffha_pkg::ST_LREAD : ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_LREAD: begin
            ram_addr = tgt_ff[GW-1:0];
            state_in = ffha_pkg::ST_LWRITE;
         end
         ffha_pkg::ST_LWRITE: begin
            // Point the following block back at its new predecessor.
            ram_we   = 1'b1;
            ram_addr = tgt_ff[GW-1:0];
            ram_wd   = '{is_free: ram_rd.is_free, size: ram_rd.size, prev: aux_ff};
            state_in = ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_RESP: begin
            done     = 1'b1;
            state_in = ffha_pkg::ST_IDLE;
         end
         default: state_in = ffha_pkg::ST_IDLE;
      endcase

      // A heap size write restarts the heap.
      if (csr_wr_en) begin
         heap_in  = GCW'(csr_clamped);
         state_in = ffha_pkg::ST_INIT;
      end
   end

   assign rsp_address           = addr_ff;
   assign rsp_used_bytes        = used_ff;
   assign rsp_free_bytes        = {heap_ff, {ffha_pkg::GSH{1'b0}}} - {1'b0, used_ff};
   assign rsp_used_block_count  = ucnt_ff;
   assign rsp_free_block_count  = fcnt_ff;
   assign rsp_total_block_count = ucnt_ff + fcnt_ff;

endmodule

// ===== tb/sv/first_fit_heap_allocator_tb.sv =====
// Self-checking testbench for first_fit_heap_allocator: directed table, then random traffic.
// Depends on ffha_pkg and the allocator RTL; carries its own model of the heap.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

   localparam int MAX_GRANULES  = ffha_pkg::MAX_GRANULES;
   localparam int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES;
   localparam logic [1:0] OP_ALLOC = ffha_pkg::OP_ALLOC;
   localparam logic [1:0] OP_FREE  = ffha_pkg::OP_FREE;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [17:0] req_request_bytes = '0;
   logic [16:0] req_free_address = '0;
   logic        done;
   logic [16:0] rsp_address;
   logic [16:0] rsp_used_bytes;
   logic [17:0] rsp_free_bytes;
   logic [11:0] rsp_used_block_count;
   logic [11:0] rsp_free_block_count;
   logic [11:0] rsp_total_block_count;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   localparam logic [1:0] OP_STATS = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   first_fit_heap_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_request_bytes(req_request_bytes),
      .req_free_address(req_free_address), .done(done),
      .rsp_address(rsp_address), .rsp_used_bytes(rsp_used_bytes),
      .rsp_free_bytes(rsp_free_bytes), .rsp_used_block_count(rsp_used_block_count),
      .rsp_free_block_count(rsp_free_block_count),
      .rsp_total_block_count(rsp_total_block_count),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [16:0] address;
      logic [16:0] used_bytes;
      logic [17:0] free_bytes;
      logic [11:0] used_cnt;
      logic [11:0] free_cnt;
      logic [11:0] total_cnt;
   } stats_type;

   // Shadow copy of the heap.
   int unsigned heap_size;
   bit          blk_free [MAX_GRANULES];
   int unsigned blk_size [MAX_GRANULES];
   int unsigned blk_prev [MAX_GRANULES];
   longint unsigned used_total;
   int unsigned     used_blk_cnt;
   int unsigned     free_blk_cnt;

   stats_type  pending_stats[$];
   int unsigned live_addrs[$];
   int          mismatch_count = 0;

   function automatic void heap_restart(int unsigned granules);
      heap_size    = granules;
      blk_free[0]  = 1'b1;
      blk_size[0]  = granules - 1;
      blk_prev[0]  = 0;
      used_total   = 0;
      used_blk_cnt = 0;
      free_blk_cnt = 1;
   endfunction

   function automatic int unsigned heap_alloc(longint unsigned bytes);
      longint unsigned need;
      int unsigned g, guard, nb, after;
      g = 0;
      guard = 0;
      if (bytes == 0) return 0;
      need = (bytes + GRANULE_BYTES - 1) / GRANULE_BYTES;
      while (g < heap_size && guard < heap_size) begin
         if (blk_free[g] && blk_size[g] >= need) begin
            blk_free[g] = 1'b0;
            if (blk_size[g] > need + 2) begin
               nb    = g + 1 + int'(need);
               after = g + 1 + blk_size[g];
               blk_free[nb] = 1'b1;
               blk_size[nb] = blk_size[g] - int'(need) - 1;
               blk_prev[nb] = g;
               if (after < heap_size) blk_prev[after] = nb;
               blk_size[g] = int'(need);
            end else begin
               free_blk_cnt--;
            end
            used_blk_cnt++;
            used_total += blk_size[g] * GRANULE_BYTES;
            return (g + 1) * GRANULE_BYTES;
         end
         g = g + 1 + blk_size[g];
         guard++;
      end
      return 0;
   endfunction

   function automatic void heap_release(int unsigned addr);
      int unsigned target, g, guard, nx, p;
      g = 0;
      guard = 0;
      if (addr == 0 || addr % GRANULE_BYTES != 0) return;
      target = addr / GRANULE_BYTES - 1;
      if (target >= heap_size) return;
      while (g < target && guard < heap_size) begin
         g = g + 1 + blk_size[g];
         guard++;
      end
      if (g != target || blk_free[g]) return;
      blk_free[g] = 1'b1;
      used_blk_cnt--;
      used_total -= blk_size[g] * GRANULE_BYTES;
      free_blk_cnt++;
      nx = g + 1 + blk_size[g];
      while (nx < heap_size && blk_free[nx]) begin
         blk_size[g] += blk_size[nx] + 1;
         free_blk_cnt--;
         nx = g + 1 + blk_size[g];
         if (nx < heap_size) blk_prev[nx] = g;
      end
      if (g != 0) begin
         p = blk_prev[g] % MAX_GRANULES;
         if (blk_free[p]) begin
            blk_size[p] += blk_size[g] + 1;
            free_blk_cnt--;
            if (nx < heap_size) blk_prev[nx] = p;
         end
      end
   endfunction

   // Applies one transaction to the shadow heap and returns the statistics it reports.
   function automatic stats_type heap_apply(logic [1:0] op, logic [17:0] bytes,
                                            logic [16:0] addr);
      stats_type s;
      int unsigned granted;
      granted = 0;
      if (op == OP_ALLOC) granted = heap_alloc(bytes);
      else if (op == OP_FREE) heap_release(addr);
      s.address    = granted[16:0];
      s.used_bytes = used_total[16:0];
      s.free_bytes = 18'(longint'(heap_size) * GRANULE_BYTES - used_total);
      s.used_cnt   = 12'(used_blk_cnt);
      s.free_cnt   = 12'(free_blk_cnt);
      s.total_cnt  = 12'(used_blk_cnt + free_blk_cnt);
      return s;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Result checking: each strobed result against the oldest expectation.
   always @(posedge clock) begin
      stats_type want;
      if (!reset && done) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("unexpected result", rsp_address, 0);
         end else begin
            want = pending_stats.pop_front();
            if (rsp_address !== want.address)
               report_mismatch("address", rsp_address, want.address);
            if (rsp_used_bytes !== want.used_bytes)
               report_mismatch("used_bytes", rsp_used_bytes, want.used_bytes);
            if (rsp_free_bytes !== want.free_bytes)
               report_mismatch("free_bytes", rsp_free_bytes, want.free_bytes);
            if (rsp_used_block_count !== want.used_cnt)
               report_mismatch("used_block_count", rsp_used_block_count, want.used_cnt);
            if (rsp_free_block_count !== want.free_cnt)
               report_mismatch("free_block_count", rsp_free_block_count, want.free_cnt);
            if (rsp_total_block_count !== want.total_cnt)
               report_mismatch("total_block_count", rsp_total_block_count, want.total_cnt);
         end
      end
   end

   bit quiet_stretch = 1'b0;

   // Drives one transaction and holds it until accepted; a typed expectation overrides.
   // Called at a falling edge; start stays high afterwards until the next drive or drain.
   task automatic send_transaction(logic [1:0] op, logic [17:0] bytes, logic [16:0] addr,
                                   bit typed, stats_type typed_want);
      stats_type s;
      if (!quiet_stretch) begin
         while ($urandom_range(99) < 28) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      req_op            <= op;
      req_request_bytes <= bytes;
      req_free_address  <= addr;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      s = heap_apply(op, bytes, addr);
      pending_stats.push_back(typed ? typed_want : s);
      if (op == OP_ALLOC && s.address != 0) live_addrs.push_back(s.address);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_stats.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_heap_size(logic [12:0] value);
      int unsigned v;
      drain_results();
      v = value;
      if (v < 2) v = 2;
      if (v > MAX_GRANULES) v = MAX_GRANULES;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      heap_restart(v);
      live_addrs.delete();
      repeat (2) @(negedge clock);
   endtask

   typedef struct {
      logic [1:0]  op;
      logic [17:0] bytes;
      logic [16:0] addr;
      bit          typed;
      stats_type   want;
   } stim_type;

   stim_type directed[$];

   // Random traffic on a heap of the given size; mostly live frees and modest allocates.
   task automatic random_phase(int n, int unsigned max_req);
      int k, idx;
      logic [1:0]  op;
      logic [17:0] bytes;
      logic [16:0] addr;
      for (k = 0; k < n; k++) begin
         quiet_stretch = (k >= n / 3 && k < n / 3 + 60);
         bytes = 18'($urandom_range(max_req));
         if ($urandom_range(19) == 0) bytes = 18'($urandom);
         addr = 17'($urandom);
         case ($urandom_range(9))
            0, 1, 2, 3: op = OP_ALLOC;
            4, 5, 6: begin
               op = OP_FREE;
               if (live_addrs.size() != 0) begin
                  idx  = $urandom_range(live_addrs.size() - 1);
                  addr = live_addrs[idx];
                  live_addrs.delete(idx);
               end
            end
            7: op = OP_FREE;
            8: op = OP_STATS;
            default: op = OP_SPARE;
         endcase
         send_transaction(op, bytes, addr, 1'b0, '0);
      end
      quiet_stretch = 1'b0;
   endtask

   initial begin
      stats_type w;
      int r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      heap_restart(MAX_GRANULES);

      // After reset: one free block of the full heap.
      w = '{17'd0, 17'd0, 18'(MAX_GRANULES * GRANULE_BYTES), 12'd0, 12'd1, 12'd1};
      directed.push_back('{OP_STATS, 18'd0, 17'd0, 1'b1, w});
      // A zero request fails and changes nothing.
      directed.push_back('{OP_ALLOC, 18'd0, 17'd0, 1'b1, w});
      // Null free is ignored.
      directed.push_back('{OP_FREE, 18'd0, 17'd0, 1'b1, w});
      directed.push_back('{OP_SPARE, 18'h3FFFF, 17'h1FFFF, 1'b1, w});
      // Largest request cannot fit (header takes a granule).
      directed.push_back('{OP_ALLOC, 18'h3FFFF, 17'd0, 1'b1, w});
      directed.push_back('{OP_ALLOC, 18'd131072, 17'd0, 1'b1, w});
      directed.push_back('{OP_ALLOC, 18'd1, 17'd0, 1'b0, w});
      directed.push_back('{OP_ALLOC, 18'd32, 17'd0, 1'b0, w});
      directed.push_back('{OP_ALLOC, 18'd33, 17'd0, 1'b0, w});
      directed.push_back('{OP_ALLOC, 18'd100, 17'd0, 1'b0, w});
      // Unaligned, inside the last free block, not a block start, then double free.
      directed.push_back('{OP_FREE, 18'd0, 17'd33, 1'b0, w});
      directed.push_back('{OP_FREE, 18'h3FFFF, 17'h1FFE0, 1'b0, w});
      directed.push_back('{OP_FREE, 18'd0, 17'd128, 1'b0, w});
      directed.push_back('{OP_FREE, 18'd0, 17'd96, 1'b0, w});
      directed.push_back('{OP_FREE, 18'd0, 17'd96, 1'b0, w});
      directed.push_back('{OP_FREE, 18'd0, 17'd32, 1'b0, w});
      directed.push_back('{OP_FREE, 18'd0, 17'd160, 1'b0, w});
      directed.push_back('{OP_ALLOC, 18'd131008, 17'd0, 1'b0, w});
      directed.push_back('{OP_FREE, 18'd0, 17'd32, 1'b0, w});
      directed.push_back('{OP_STATS, 18'd0, 17'd0, 1'b0, w});
      foreach (directed[i])
         send_transaction(directed[i].op, directed[i].bytes, directed[i].addr,
                          directed[i].typed, directed[i].want);

      // Smallest heap: an exact fit and a register value below range.
      write_heap_size(13'd0);
      send_transaction(OP_ALLOC, 18'd32, 17'd0, 1'b0, '0);
      send_transaction(OP_ALLOC, 18'd1, 17'd0, 1'b0, '0);
      send_transaction(OP_FREE, 18'd0, 17'd32, 1'b0, '0);
      random_phase(60, 80);

      write_heap_size(13'h1FFF);
      random_phase(500, 2000);
      write_heap_size(13'd16);
      random_phase(400, 200);
      write_heap_size(13'd4);
      random_phase(200, 120);
      write_heap_size(13'd2);
      random_phase(60, 40);
      r = $urandom_range(64, 1024);
      write_heap_size(13'(r));
      random_phase(400, 3000);
      write_heap_size(13'd4096);
      random_phase(300, 8000);

      drain_results();
      if (mismatch_count == 0) begin
         $display("first_fit_heap_allocator_tb OK");
      end else begin
         $display("first_fit_heap_allocator_tb NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1s;
      $display("first_fit_heap_allocator_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
